// ===== src/aff2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aff2d_pkg
// Shared constants, types, CORDIC arctangent table and the sequencer program
// of the 2D affine transform unit.
// ----------------------------------------------------------------------------
package aff2d_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int ANG_FRAC     = 24;
	localparam int CORD_FRAC    = 30;

	// datapath widths
	localparam int OPW  = 33;
	localparam int PRW  = 2 * OPW;
	localparam int ACCW = PRW - FRAC_BITS + 2;
	localparam int CW   = 34;
	localparam int USW  = FRAC_BITS + 2;

	// angle reduction: conditional subtracts of one turn shifted by RED_K..0
	localparam int RED_K  = (FRAC_BITS < 23) ? 23 - FRAC_BITS : 0;
	localparam int ZW     = (58 - FRAC_BITS > 36) ? 58 - FRAC_BITS : 36;
	localparam int RSH_W  = $clog2(RED_K + 2);
	localparam int CIT_W  = $clog2(CORDIC_STEPS);
	localparam int CNT_W  = (RSH_W > CIT_W) ? RSH_W : CIT_W;
	localparam int PC_W   = 6;

	localparam logic signed [ZW-1:0] FULL_TURN = ZW'(64'd360 << ANG_FRAC);
	localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'd180 << ANG_FRAC);
	localparam logic signed [ZW-1:0] QUARTER   = ZW'(64'd90 << ANG_FRAC);
	localparam logic signed [CW-1:0] CORD_GAIN = CW'(64'd652032874);
	localparam logic signed [31:0]   ONE       = 32'(64'd1 << FRAC_BITS);

	typedef enum logic [2:0] {
		OP_IDENT = 3'd0,
		OP_TRANS = 3'd1,
		OP_ROT   = 3'd2,
		OP_SCALE = 3'd3,
		OP_POINT = 3'd4,
		OP_RECT  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_FOLD,
		ST_CORD,
		ST_SC,
		ST_SEQ,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		U_NOP,
		U_MUL,
		U_SETOP,
		U_COMMIT,
		U_IDENT,
		U_CORNER,
		U_BOX
	} kind_t;

	typedef enum logic [4:0] {
		S_A, S_B, S_D, S_E,
		S_P, S_Q, S_R, S_S, S_T, S_U,
		S_PX, S_PY, S_EX, S_EY, S_RX, S_BY,
		S_OMC, S_SN, S_OMPX, S_OMPY, S_NONE
	} src_t;

	typedef enum logic [1:0] {
		B_ZERO,
		B_TX,
		B_TY
	} base_t;

	typedef enum logic [3:0] {
		D_N0, D_N1, D_N2, D_N3, D_N4, D_N5,
		D_R, D_U,
		D_CX0, D_CX1, D_CX2, D_CX3,
		D_CY0, D_CY1, D_CY2, D_CY3
	} dst_t;

	typedef struct packed {
		kind_t kind;
		src_t  sa;
		src_t  sb;
		logic  clr;
		base_t base;
		logic  neg;
		logic  wb;
		dst_t  dst;
		logic  to_comb;
		logic  last;
	} uop_t;

	typedef struct packed {
		logic             load;
		logic             red_step;
		logic [RSH_W-1:0] red_sh;
		logic             fold;
		logic             cord;
		logic [CIT_W-1:0] cord_i;
		logic             sincos;
		logic             uop_en;
		uop_t             uop;
		logic             fin;
	} dp_cmd_t;

	// program entry points
	localparam logic [PC_W-1:0] ROT_PC  = 6'd0;
	localparam logic [PC_W-1:0] SCL_PC  = 6'd6;
	localparam logic [PC_W-1:0] TRN_PC  = 6'd10;
	localparam logic [PC_W-1:0] COMB_PC = 6'd11;
	localparam logic [PC_W-1:0] PNT_PC  = 6'd25;
	localparam logic [PC_W-1:0] RCT_PC  = 6'd30;
	localparam logic [PC_W-1:0] ID_PC   = 6'd49;

	function automatic logic signed [CW-1:0] atan_deg(input logic [4:0] i);
		logic signed [CW-1:0] v;
		case (i)
			5'd0:  v = CW'(64'd754974720);
			5'd1:  v = CW'(64'd445687602);
			5'd2:  v = CW'(64'd235489088);
			5'd3:  v = CW'(64'd119537938);
			5'd4:  v = CW'(64'd60000934);
			5'd5:  v = CW'(64'd30029717);
			5'd6:  v = CW'(64'd15018523);
			5'd7:  v = CW'(64'd7509720);
			5'd8:  v = CW'(64'd3754917);
			5'd9:  v = CW'(64'd1877466);
			5'd10: v = CW'(64'd938734);
			5'd11: v = CW'(64'd469367);
			5'd12: v = CW'(64'd234684);
			5'd13: v = CW'(64'd117342);
			5'd14: v = CW'(64'd58671);
			5'd15: v = CW'(64'd29335);
			5'd16: v = CW'(64'd14668);
			5'd17: v = CW'(64'd7334);
			5'd18: v = CW'(64'd3667);
			5'd19: v = CW'(64'd1833);
			5'd20: v = CW'(64'd917);
			5'd21: v = CW'(64'd458);
			5'd22: v = CW'(64'd229);
			5'd23: v = CW'(64'd115);
			5'd24: v = CW'(64'd57);
			5'd25: v = CW'(64'd29);
			5'd26: v = CW'(64'd14);
			5'd27: v = CW'(64'd7);
			5'd28: v = CW'(64'd4);
			5'd29: v = CW'(64'd2);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic uop_t mk(input kind_t k, input src_t sa, input src_t sb,
			input logic clr, input base_t base, input logic neg, input logic wb,
			input dst_t dst, input logic to_comb, input logic last);
		uop_t u;
		u.kind    = k;
		u.sa      = sa;
		u.sb      = sb;
		u.clr     = clr;
		u.base    = base;
		u.neg     = neg;
		u.wb      = wb;
		u.dst     = dst;
		u.to_comb = to_comb;
		u.last    = last;
		return u;
	endfunction

	function automatic uop_t mul(input src_t sa, input src_t sb, input logic clr,
			input base_t base, input logic neg, input logic wb, input dst_t dst);
		return mk(U_MUL, sa, sb, clr, base, neg, wb, dst, 1'b0, 1'b0);
	endfunction

	function automatic uop_t ctl(input kind_t k, input logic to_comb, input logic last);
		return mk(k, S_NONE, S_NONE, 1'b0, B_ZERO, 1'b0, 1'b0, D_N0, to_comb, last);
	endfunction

	// sequencer program: at most one multiply issued per step, sum written on wb
	function automatic uop_t prog(input logic [PC_W-1:0] pc);
		uop_t u;
		unique case (pc)
			// rotate: operation matrix, then offsets about the center
			6'd0:  u = ctl(U_SETOP, 1'b0, 1'b0);
			6'd1:  u = mul(S_EX, S_OMC, 1'b1, B_ZERO, 1'b0, 1'b0, D_R);
			6'd2:  u = mul(S_EY, S_SN,  1'b0, B_ZERO, 1'b0, 1'b1, D_R);
			6'd3:  u = mul(S_EY, S_OMC, 1'b1, B_ZERO, 1'b0, 1'b0, D_U);
			6'd4:  u = mul(S_EX, S_SN,  1'b0, B_ZERO, 1'b1, 1'b1, D_U);
			6'd5:  u = ctl(U_NOP, 1'b1, 1'b0);
			// scale
			6'd6:  u = ctl(U_SETOP, 1'b0, 1'b0);
			6'd7:  u = mul(S_EX, S_OMPX, 1'b1, B_ZERO, 1'b0, 1'b1, D_R);
			6'd8:  u = mul(S_EY, S_OMPY, 1'b1, B_ZERO, 1'b0, 1'b1, D_U);
			6'd9:  u = ctl(U_NOP, 1'b1, 1'b0);
			// translate
			6'd10: u = ctl(U_SETOP, 1'b1, 1'b0);
			// M := M * op matrix
			6'd11: u = mul(S_A, S_P, 1'b1, B_ZERO, 1'b0, 1'b0, D_N0);
			6'd12: u = mul(S_B, S_S, 1'b0, B_ZERO, 1'b0, 1'b1, D_N0);
			6'd13: u = mul(S_A, S_Q, 1'b1, B_ZERO, 1'b0, 1'b0, D_N1);
			6'd14: u = mul(S_B, S_T, 1'b0, B_ZERO, 1'b0, 1'b1, D_N1);
			6'd15: u = mul(S_A, S_R, 1'b1, B_TX,   1'b0, 1'b0, D_N2);
			6'd16: u = mul(S_B, S_U, 1'b0, B_ZERO, 1'b0, 1'b1, D_N2);
			6'd17: u = mul(S_D, S_P, 1'b1, B_ZERO, 1'b0, 1'b0, D_N3);
			6'd18: u = mul(S_E, S_S, 1'b0, B_ZERO, 1'b0, 1'b1, D_N3);
			6'd19: u = mul(S_D, S_Q, 1'b1, B_ZERO, 1'b0, 1'b0, D_N4);
			6'd20: u = mul(S_E, S_T, 1'b0, B_ZERO, 1'b0, 1'b1, D_N4);
			6'd21: u = mul(S_D, S_R, 1'b1, B_TY,   1'b0, 1'b0, D_N5);
			6'd22: u = mul(S_E, S_U, 1'b0, B_ZERO, 1'b0, 1'b1, D_N5);
			6'd23: u = ctl(U_NOP, 1'b0, 1'b0);
			6'd24: u = ctl(U_COMMIT, 1'b0, 1'b1);
			// map point
			6'd25: u = mul(S_A, S_PX, 1'b1, B_TX,   1'b0, 1'b0, D_CX0);
			6'd26: u = mul(S_B, S_PY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CX0);
			6'd27: u = mul(S_D, S_PX, 1'b1, B_TY,   1'b0, 1'b0, D_CY0);
			6'd28: u = mul(S_E, S_PY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CY0);
			6'd29: u = ctl(U_NOP, 1'b0, 1'b1);
			// map rectangle: four corners, then bounding box
			6'd30: u = ctl(U_CORNER, 1'b0, 1'b0);
			6'd31: u = mul(S_A, S_PX, 1'b1, B_TX,   1'b0, 1'b0, D_CX0);
			6'd32: u = mul(S_B, S_PY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CX0);
			6'd33: u = mul(S_D, S_PX, 1'b1, B_TY,   1'b0, 1'b0, D_CY0);
			6'd34: u = mul(S_E, S_PY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CY0);
			6'd35: u = mul(S_A, S_PX, 1'b1, B_TX,   1'b0, 1'b0, D_CX1);
			6'd36: u = mul(S_B, S_BY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CX1);
			6'd37: u = mul(S_D, S_PX, 1'b1, B_TY,   1'b0, 1'b0, D_CY1);
			6'd38: u = mul(S_E, S_BY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CY1);
			6'd39: u = mul(S_A, S_RX, 1'b1, B_TX,   1'b0, 1'b0, D_CX2);
			6'd40: u = mul(S_B, S_PY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CX2);
			6'd41: u = mul(S_D, S_RX, 1'b1, B_TY,   1'b0, 1'b0, D_CY2);
			6'd42: u = mul(S_E, S_PY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CY2);
			6'd43: u = mul(S_A, S_RX, 1'b1, B_TX,   1'b0, 1'b0, D_CX3);
			6'd44: u = mul(S_B, S_BY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CX3);
			6'd45: u = mul(S_D, S_RX, 1'b1, B_TY,   1'b0, 1'b0, D_CY3);
			6'd46: u = mul(S_E, S_BY, 1'b0, B_ZERO, 1'b0, 1'b1, D_CY3);
			6'd47: u = ctl(U_NOP, 1'b0, 1'b0);
			6'd48: u = ctl(U_BOX, 1'b0, 1'b1);
			// identity
			6'd49: u = ctl(U_IDENT, 1'b0, 1'b1);
			default: u = ctl(U_NOP, 1'b0, 1'b1);
		endcase
		return u;
	endfunction

endpackage

// ===== src/aff2d_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aff2d_ctrl
// Controller: accepts commands, walks angle reduction, CORDIC iterations and
// the multiply program, and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module aff2d_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         opcode,
	output logic               busy,
	output aff2d_pkg::dp_cmd_t cmd
);
	import aff2d_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [PC_W-1:0]   pc_q, pc_d;
	uop_t              cur;

	assign cur  = prog(pc_q);
	assign busy = (state_q != ST_IDLE);

	// hold state, step counter and program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pc_q    <= pc_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		pc_d         = pc_q;
		cmd          = '0;
		cmd.red_sh   = RSH_W'(cnt_q);
		cmd.cord_i   = CIT_W'(cnt_q);
		cmd.uop      = cur;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (opcode)
						OP_IDENT: begin
							state_d = ST_SEQ;
							pc_d    = ID_PC;
						end
						OP_TRANS: begin
							state_d = ST_SEQ;
							pc_d    = TRN_PC;
						end
						OP_ROT: begin
							state_d = ST_RED;
							cnt_d   = CNT_W'(RED_K);
						end
						OP_SCALE: begin
							state_d = ST_SEQ;
							pc_d    = SCL_PC;
						end
						OP_POINT: begin
							state_d = ST_SEQ;
							pc_d    = PNT_PC;
						end
						OP_RECT: begin
							state_d = ST_SEQ;
							pc_d    = RCT_PC;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_FOLD;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				cnt_d    = '0;
				state_d  = ST_CORD;
			end
			ST_CORD: begin
				cmd.cord = 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					state_d = ST_SC;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_SC: begin
				cmd.sincos = 1'b1;
				pc_d       = ROT_PC;
				state_d    = ST_SEQ;
			end
			ST_SEQ: begin
				cmd.uop_en = 1'b1;
				if (cur.last) begin
					state_d = ST_FIN;
				end else if (cur.to_comb) begin
					pc_d = COMB_PC;
				end else begin
					pc_d = pc_q + 1'b1;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== src/aff2d_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aff2d_dp
// Datapath: matrix registers, angle reducer, CORDIC unit, one shared
// multiplier with rounding accumulator, bounding box and result registers.
// ----------------------------------------------------------------------------
module aff2d_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  aff2d_pkg::dp_cmd_t cmd,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] ext_x,
	input  logic signed [31:0] ext_y,
	input  logic signed [31:0] angle_deg,
	output logic               res_valid,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_w,
	output logic signed [31:0] res_h,
	output logic               saturated
);
	import aff2d_pkg::*;

	localparam logic signed [ACCW-1:0] S32_MAX = ACCW'(64'sd2147483647);
	localparam logic signed [ACCW-1:0] S32_MIN = ACCW'(-64'sd2147483648);
	localparam logic signed [PRW-1:0]  RND     = PRW'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [CW-1:0]   CRND    = CW'(64'd1 << (CORD_FRAC - FRAC_BITS - 1));
	localparam logic signed [CW-1:0]   C_ONE   = CW'(ONE);
	localparam logic signed [CW-1:0]   C_MONE  = -C_ONE;

	function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic ovf32(input logic signed [ACCW-1:0] v);
		return (v > S32_MAX) || (v < S32_MIN);
	endfunction

	// matrix and operation matrix
	logic signed [31:0]     m_q [6];
	logic signed [31:0]     n_q [6];
	logic signed [31:0]     p_q, q_q, r_q, s_q, t_q, u_q;
	// latched item
	logic [2:0]             op_q;
	logic signed [31:0]     px_q, py_q, ex_q, ey_q, rx_q, by_q;
	logic                   flag_q;
	// angle and CORDIC
	logic signed [ZW-1:0]   z_q;
	logic signed [CW-1:0]   cor_x_q, cor_y_q, cor_z_q;
	logic                   neg_q;
	logic signed [USW-1:0]  cs_q, sn_q;
	// multiply pipeline
	logic                   mul_s1;
	logic signed [PRW-1:0]  prod_s1;
	logic signed [31:0]     base_s1;
	uop_t                   uop_s1;
	logic signed [ACCW-1:0] acc_q;
	// corners and box
	logic signed [31:0]     kx_q [4];
	logic signed [31:0]     ky_q [4];
	logic signed [31:0]     lox_q, hix_q, loy_q, hiy_q;
	// results
	logic                   res_valid_q;
	logic signed [31:0]     res_x_q, res_y_q, res_w_q, res_h_q;
	logic                   sat_q;

	// combinational helpers
	logic signed [OPW-1:0]  opa, opb;
	logic signed [31:0]     base_v;
	logic signed [ZW-1:0]   z_init, red_sub, fz;
	logic                   fneg;
	logic signed [CW-1:0]   dx, dy, at, xv, yv, xr, yr;
	logic signed [ACCW-1:0] rnd, term, sum;
	logic signed [ACCW-1:0] cx_sum, cy_sum, bw, bh;
	logic signed [31:0]     mnx, mxx, mny, mxy;

	function automatic logic signed [OPW-1:0] pick(input src_t s,
			input logic signed [31:0] ma, input logic signed [31:0] mb,
			input logic signed [31:0] md, input logic signed [31:0] me,
			input logic signed [31:0] vp, input logic signed [31:0] vq,
			input logic signed [31:0] vr, input logic signed [31:0] vs,
			input logic signed [31:0] vt, input logic signed [31:0] vu,
			input logic signed [31:0] vpx, input logic signed [31:0] vpy,
			input logic signed [31:0] vex, input logic signed [31:0] vey,
			input logic signed [31:0] vrx, input logic signed [31:0] vby,
			input logic signed [USW-1:0] vcs, input logic signed [USW-1:0] vsn);
		logic signed [OPW-1:0] v;
		case (s)
			S_A:    v = OPW'(ma);
			S_B:    v = OPW'(mb);
			S_D:    v = OPW'(md);
			S_E:    v = OPW'(me);
			S_P:    v = OPW'(vp);
			S_Q:    v = OPW'(vq);
			S_R:    v = OPW'(vr);
			S_S:    v = OPW'(vs);
			S_T:    v = OPW'(vt);
			S_U:    v = OPW'(vu);
			S_PX:   v = OPW'(vpx);
			S_PY:   v = OPW'(vpy);
			S_EX:   v = OPW'(vex);
			S_EY:   v = OPW'(vey);
			S_RX:   v = OPW'(vrx);
			S_BY:   v = OPW'(vby);
			S_OMC:  v = OPW'(ONE) - OPW'(vcs);
			S_SN:   v = OPW'(vsn);
			S_OMPX: v = OPW'(ONE) - OPW'(vpx);
			S_OMPY: v = OPW'(ONE) - OPW'(vpy);
			default: v = '0;
		endcase
		return v;
	endfunction

	// select multiplier operands and accumulator base
	always_comb begin
		opa = pick(cmd.uop.sa, m_q[0], m_q[1], m_q[3], m_q[4], p_q, q_q, r_q, s_q,
			t_q, u_q, px_q, py_q, ex_q, ey_q, rx_q, by_q, cs_q, sn_q);
		opb = pick(cmd.uop.sb, m_q[0], m_q[1], m_q[3], m_q[4], p_q, q_q, r_q, s_q,
			t_q, u_q, px_q, py_q, ex_q, ey_q, rx_q, by_q, cs_q, sn_q);
		case (cmd.uop.base)
			B_TX:    base_v = m_q[2];
			B_TY:    base_v = m_q[5];
			default: base_v = '0;
		endcase
	end

	// angle widening, reduction step and fold into [-90,90]
	always_comb begin
		z_init = ZW'(angle_deg) <<< (ANG_FRAC - FRAC_BITS);
		if (angle_deg < 0) begin
			z_init = z_init + (FULL_TURN <<< RED_K);
		end
		red_sub = FULL_TURN <<< cmd.red_sh;
		fz      = z_q;
		fneg    = 1'b0;
		if (fz >= HALF_TURN) begin
			fz = fz - FULL_TURN;
		end
		if (fz > QUARTER) begin
			fz   = fz - HALF_TURN;
			fneg = 1'b1;
		end else if (fz < -QUARTER) begin
			fz   = fz + HALF_TURN;
			fneg = 1'b1;
		end
	end

	// CORDIC rotation step and sin/cos rounding
	always_comb begin
		dx = cor_y_q >>> cmd.cord_i;
		dy = cor_x_q >>> cmd.cord_i;
		at = atan_deg(5'(cmd.cord_i));
		xv = neg_q ? -cor_x_q : cor_x_q;
		yv = neg_q ? -cor_y_q : cor_y_q;
		xr = (xv + CRND) >>> (CORD_FRAC - FRAC_BITS);
		yr = (yv + CRND) >>> (CORD_FRAC - FRAC_BITS);
		if (xr > C_ONE) begin
			xr = C_ONE;
		end else if (xr < C_MONE) begin
			xr = C_MONE;
		end
		if (yr > C_ONE) begin
			yr = C_ONE;
		end else if (yr < C_MONE) begin
			yr = C_MONE;
		end
	end

	// round the product and accumulate
	always_comb begin
		rnd    = ACCW'((prod_s1 + RND) >>> FRAC_BITS);
		term   = uop_s1.neg ? -rnd : rnd;
		sum    = (uop_s1.clr ? ACCW'(base_s1) : acc_q) + term;
		cx_sum = ACCW'(px_q) + ACCW'(ex_q);
		cy_sum = ACCW'(py_q) + ACCW'(ey_q);
		bw     = ACCW'(hix_q) - ACCW'(lox_q);
		bh     = ACCW'(hiy_q) - ACCW'(loy_q);
	end

	// min and max over the four corners
	always_comb begin
		mnx = kx_q[0];
		mxx = kx_q[0];
		mny = ky_q[0];
		mxy = ky_q[0];
		for (int k = 1; k < 4; k++) begin
			if (kx_q[k] < mnx) mnx = kx_q[k];
			if (kx_q[k] > mxx) mxx = kx_q[k];
			if (ky_q[k] < mny) mny = ky_q[k];
			if (ky_q[k] > mxy) mxy = ky_q[k];
		end
	end

	// control registers and matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s1      <= 1'b0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < 6; k++) begin
				m_q[k] <= (k == 0 || k == 4) ? ONE : 32'sd0;
			end
		end else begin
			mul_s1      <= cmd.uop_en && (cmd.uop.kind == U_MUL);
			res_valid_q <= cmd.fin;
			if (cmd.uop_en && (cmd.uop.kind == U_COMMIT)) begin
				for (int k = 0; k < 6; k++) begin
					m_q[k] <= n_q[k];
				end
			end else if (cmd.uop_en && (cmd.uop.kind == U_IDENT)) begin
				for (int k = 0; k < 6; k++) begin
					m_q[k] <= (k == 0 || k == 4) ? ONE : 32'sd0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			px_q   <= pos_x;
			py_q   <= pos_y;
			ex_q   <= ext_x;
			ey_q   <= ext_y;
			z_q    <= z_init;
			flag_q <= 1'b0;
		end
		if (cmd.red_step && (z_q >= red_sub)) begin
			z_q <= z_q - red_sub;
		end
		if (cmd.fold) begin
			cor_z_q <= CW'(fz);
			neg_q   <= fneg;
			cor_x_q <= CORD_GAIN;
			cor_y_q <= '0;
		end
		if (cmd.cord) begin
			if (!cor_z_q[CW-1]) begin
				cor_x_q <= cor_x_q - dx;
				cor_y_q <= cor_y_q + dy;
				cor_z_q <= cor_z_q - at;
			end else begin
				cor_x_q <= cor_x_q + dx;
				cor_y_q <= cor_y_q - dy;
				cor_z_q <= cor_z_q + at;
			end
		end
		if (cmd.sincos) begin
			cs_q <= USW'(xr);
			sn_q <= USW'(yr);
		end

		// issue stage
		if (cmd.uop_en) begin
			case (cmd.uop.kind)
				U_MUL: begin
					prod_s1 <= opa * opb;
					base_s1 <= base_v;
					uop_s1  <= cmd.uop;
				end
				U_SETOP: begin
					case (op_q)
						OP_ROT: begin
							p_q <= 32'(cs_q);
							q_q <= -32'(sn_q);
							s_q <= 32'(sn_q);
							t_q <= 32'(cs_q);
						end
						OP_SCALE: begin
							p_q <= px_q;
							q_q <= '0;
							s_q <= '0;
							t_q <= py_q;
						end
						default: begin
							p_q <= ONE;
							q_q <= '0;
							r_q <= px_q;
							s_q <= '0;
							t_q <= ONE;
							u_q <= py_q;
						end
					endcase
				end
				U_CORNER: begin
					rx_q <= sat32(cx_sum);
					by_q <= sat32(cy_sum);
					if (ovf32(cx_sum) || ovf32(cy_sum)) flag_q <= 1'b1;
				end
				U_BOX: begin
					lox_q <= mnx;
					hix_q <= mxx;
					loy_q <= mny;
					hiy_q <= mxy;
				end
				default: ;
			endcase
		end

		// accumulate stage, write back saturated sums
		if (mul_s1) begin
			acc_q <= sum;
			if (uop_s1.wb) begin
				if (ovf32(sum)) flag_q <= 1'b1;
				case (uop_s1.dst)
					D_N0:  n_q[0] <= sat32(sum);
					D_N1:  n_q[1] <= sat32(sum);
					D_N2:  n_q[2] <= sat32(sum);
					D_N3:  n_q[3] <= sat32(sum);
					D_N4:  n_q[4] <= sat32(sum);
					D_N5:  n_q[5] <= sat32(sum);
					D_R:   r_q    <= sat32(sum);
					D_U:   u_q    <= sat32(sum);
					D_CX0: kx_q[0] <= sat32(sum);
					D_CX1: kx_q[1] <= sat32(sum);
					D_CX2: kx_q[2] <= sat32(sum);
					D_CX3: kx_q[3] <= sat32(sum);
					D_CY0: ky_q[0] <= sat32(sum);
					D_CY1: ky_q[1] <= sat32(sum);
					D_CY2: ky_q[2] <= sat32(sum);
					D_CY3: ky_q[3] <= sat32(sum);
					default: ;
				endcase
			end
		end

		// result registers
		if (cmd.fin) begin
			case (op_t'(op_q))
				OP_POINT: begin
					res_x_q <= kx_q[0];
					res_y_q <= ky_q[0];
					res_w_q <= '0;
					res_h_q <= '0;
					sat_q   <= flag_q;
				end
				OP_RECT: begin
					res_x_q <= lox_q;
					res_y_q <= loy_q;
					res_w_q <= sat32(bw);
					res_h_q <= sat32(bh);
					sat_q   <= flag_q || ovf32(bw) || ovf32(bh);
				end
				default: begin
					res_x_q <= '0;
					res_y_q <= '0;
					res_w_q <= '0;
					res_h_q <= '0;
					sat_q   <= flag_q;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_x     = res_x_q;
	assign res_y     = res_y_q;
	assign res_w     = res_w_q;
	assign res_h     = res_h_q;
	assign saturated = sat_q;

endmodule

// ===== src/affine_2d_transform_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_2d_transform_unit
// 2D affine transform unit: keeps a Q16.16 matrix, applies translate,
// rotate and scale about a center, and maps points and rectangles.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------
//  command   | start, busy        | opcode, pos_x, pos_y, ext_x, ext_y,
//            |                    | angle_deg
//  result    | res_valid (strobe) | res_x, res_y, res_w, res_h, saturated
//
// A command transfers when start is high and busy is low. A rotate walks
// 8 reduction steps, one fold, 16 CORDIC steps, one sin/cos step, then
// 20 program steps; the single shared multiplier, one product per cycle,
// sets the program length.
// Opcodes 6 and 7 transfer, give no result and leave busy low. A result shows
// for one cycle on res_valid; the next command may transfer in that cycle.
// Reset loads the identity matrix.
// ----------------------------------------------------------------------------
module affine_2d_transform_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] ext_x,
	input  logic signed [31:0] ext_y,
	input  logic signed [31:0] angle_deg,
	output logic               res_valid,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_w,
	output logic signed [31:0] res_h,
	output logic               saturated
);
	import aff2d_pkg::*;

	dp_cmd_t cmd;

	// sequence the work
	aff2d_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.busy   (busy),
		.cmd    (cmd)
	);

	// compute and hold results
	aff2d_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.opcode    (opcode),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.ext_x     (ext_x),
		.ext_y     (ext_y),
		.angle_deg (angle_deg),
		.res_valid (res_valid),
		.res_x     (res_x),
		.res_y     (res_y),
		.res_w     (res_w),
		.res_h     (res_h),
		.saturated (saturated)
	);

endmodule

// ===== bench/affine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_checker
// Watches the command and result channels of the affine transform unit,
// keeps its own copy of the matrix, predicts every result bit for bit and
// compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module affine_checker
	import aff2d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] ext_x,
	input  logic signed [31:0] ext_y,
	input  logic signed [31:0] angle_deg,
	input  logic               res_valid,
	input  logic signed [31:0] res_x,
	input  logic signed [31:0] res_y,
	input  logic signed [31:0] res_w,
	input  logic signed [31:0] res_h,
	input  logic               saturated,
	output int                 fails,
	output int                 pending
);

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] w;
		logic [31:0] h;
		logic        sat;
	} box_t;

	localparam longint UNIT     = longint'(1) <<< FRAC_BITS;
	localparam longint DEG      = longint'(1) <<< ANG_FRAC;
	localparam longint GAIN     = 64'd652032874;
	localparam longint I32_MAX  = 64'sd2147483647;
	localparam longint I32_MIN  = -64'sd2147483648;
	localparam longint ATAN_TAB [30] = '{
		754974720, 445687602, 235489088, 119537938, 60000934,
		30029717, 15018523, 7509720, 3754917, 1877466,
		938734, 469367, 234684, 117342, 58671,
		29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57,
		29, 14, 7, 4, 2
	};

	longint mtx [6];
	box_t   expected_boxes [$];
	int     mism;

	assign pending = expected_boxes.size();

	function automatic longint clamp32(input longint v, inout bit f);
		if (v > I32_MAX) begin
			f = 1'b1;
			return I32_MAX;
		end
		if (v < I32_MIN) begin
			f = 1'b1;
			return I32_MIN;
		end
		return v;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic longint clamp_one(input longint v);
		if (v > UNIT) return UNIT;
		if (v < -UNIT) return -UNIT;
		return v;
	endfunction

	// M := M * [[p q r] [s t u] [0 0 1]]
	function automatic void compose(input longint p, input longint q, input longint r,
			input longint s, input longint t, input longint u, inout bit f);
		longint a, b, tx, d, e, ty;
		a = mtx[0]; b = mtx[1]; tx = mtx[2];
		d = mtx[3]; e = mtx[4]; ty = mtx[5];
		mtx[0] = clamp32(fx_mul(a, p) + fx_mul(b, s), f);
		mtx[1] = clamp32(fx_mul(a, q) + fx_mul(b, t), f);
		mtx[2] = clamp32(fx_mul(a, r) + fx_mul(b, u) + tx, f);
		mtx[3] = clamp32(fx_mul(d, p) + fx_mul(e, s), f);
		mtx[4] = clamp32(fx_mul(d, q) + fx_mul(e, t), f);
		mtx[5] = clamp32(fx_mul(d, r) + fx_mul(e, u) + ty, f);
	endfunction

	function automatic void map_xy(input longint x, input longint y, output longint ox,
			output longint oy, inout bit f);
		ox = clamp32(fx_mul(mtx[0], x) + fx_mul(mtx[1], y) + mtx[2], f);
		oy = clamp32(fx_mul(mtx[3], x) + fx_mul(mtx[4], y) + mtx[5], f);
	endfunction

	// reduce the angle, fold to [-90,90] and run the degree CORDIC
	function automatic void sine_cosine(input longint ang, output longint sn,
			output longint cs);
		longint z, x, y, dx, dy, full;
		bit     flip;
		full = 360 * DEG;
		z = (ang * (longint'(1) <<< (ANG_FRAC - FRAC_BITS))) % full;
		x = GAIN;
		y = 0;
		flip = 1'b0;
		if (z < 0) z += full;
		if (z >= 180 * DEG) z -= full;
		if (z > 90 * DEG) begin
			z -= 180 * DEG;
			flip = 1'b1;
		end else if (z < -90 * DEG) begin
			z += 180 * DEG;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cs = clamp_one((x + (longint'(1) <<< (CORD_FRAC - FRAC_BITS - 1)))
			>>> (CORD_FRAC - FRAC_BITS));
		sn = clamp_one((y + (longint'(1) <<< (CORD_FRAC - FRAC_BITS - 1)))
			>>> (CORD_FRAC - FRAC_BITS));
	endfunction

	function automatic void load_identity();
		for (int i = 0; i < 6; i++) mtx[i] = 0;
		mtx[0] = UNIT;
		mtx[4] = UNIT;
	endfunction

	// predict the result of one command; returns 0 for spare opcodes
	function automatic bit predict_box(input logic [2:0] op, input longint px,
			input longint py, input longint ex, input longint ey, input longint ang,
			output box_t bx);
		longint r [4];
		longint sn, cs, tr, tu, rx, by, lx, hx, ly, hy;
		longint cx [4];
		longint cy [4];
		bit     f;
		f = 1'b0;
		r = '{0, 0, 0, 0};
		case (op)
			OP_IDENT: load_identity();
			OP_TRANS: compose(UNIT, 0, px, 0, UNIT, py, f);
			OP_ROT: begin
				sine_cosine(ang, sn, cs);
				tr = clamp32(fx_mul(ex, UNIT - cs) + fx_mul(ey, sn), f);
				tu = clamp32(fx_mul(ey, UNIT - cs) - fx_mul(ex, sn), f);
				compose(cs, -sn, tr, sn, cs, tu, f);
			end
			OP_SCALE: begin
				tr = clamp32(fx_mul(ex, UNIT - px), f);
				tu = clamp32(fx_mul(ey, UNIT - py), f);
				compose(px, 0, tr, 0, py, tu, f);
			end
			OP_POINT: map_xy(px, py, r[0], r[1], f);
			OP_RECT: begin
				rx = clamp32(px + ex, f);
				by = clamp32(py + ey, f);
				map_xy(px, py, cx[0], cy[0], f);
				map_xy(px, by, cx[1], cy[1], f);
				map_xy(rx, py, cx[2], cy[2], f);
				map_xy(rx, by, cx[3], cy[3], f);
				lx = cx[0]; hx = cx[0]; ly = cy[0]; hy = cy[0];
				for (int k = 1; k < 4; k++) begin
					if (cx[k] < lx) lx = cx[k];
					if (cx[k] > hx) hx = cx[k];
					if (cy[k] < ly) ly = cy[k];
					if (cy[k] > hy) hy = cy[k];
				end
				r[0] = lx;
				r[1] = ly;
				r[2] = clamp32(hx - lx, f);
				r[3] = clamp32(hy - ly, f);
			end
			default: return 1'b0;
		endcase
		bx.x = r[0][31:0];
		bx.y = r[1][31:0];
		bx.w = r[2][31:0];
		bx.h = r[3][31:0];
		bx.sat = f;
		return 1'b1;
	endfunction

	// compare results first, then predict the command of the same edge
	always @(posedge clk or negedge arst_n) begin
		box_t got, want;
		if (!arst_n) begin
			load_identity();
			expected_boxes.delete();
			fails = 0;
			mism = 0;
		end else begin
			if (res_valid) begin
				got.x = res_x; got.y = res_y; got.w = res_w; got.h = res_h;
				got.sat = saturated;
				if (expected_boxes.size() == 0) begin
					fails++;
					if (mism < 10)
						$display("unexpected result x=%h y=%h w=%h h=%h sat=%b",
							got.x, got.y, got.w, got.h, got.sat);
					mism++;
				end else begin
					want = expected_boxes.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
							got.h !== want.h || got.sat !== want.sat) begin
						fails++;
						if (mism < 10)
							$display("mismatch exp x=%h y=%h w=%h h=%h sat=%b got x=%h y=%h w=%h h=%h sat=%b",
								want.x, want.y, want.w, want.h, want.sat,
								got.x, got.y, got.w, got.h, got.sat);
						mism++;
					end
				end
			end
			if (start && !busy) begin
				if (predict_box(opcode, longint'(pos_x), longint'(pos_y),
						longint'(ext_x), longint'(ext_y), longint'(angle_deg), want))
					expected_boxes.push_back(want);
			end
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the affine transform unit with directed edge cases and then random
// transform and mapping sequences under three sender gap profiles; the
// checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import aff2d_pkg::*;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int         WDOG_MAX  = 2000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         opcode;
	logic signed [31:0] pos_x, pos_y, ext_x, ext_y, angle_deg;
	logic               res_valid;
	logic signed [31:0] res_x, res_y, res_w, res_h;
	logic               saturated;
	int                 fails;
	int                 pending;
	int                 idle_pct;
	int                 quiet_cycles;

	affine_2d_transform_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.pos_x(pos_x), .pos_y(pos_y), .ext_x(ext_x), .ext_y(ext_y),
		.angle_deg(angle_deg), .res_valid(res_valid), .res_x(res_x), .res_y(res_y),
		.res_w(res_w), .res_h(res_h), .saturated(saturated)
	);

	affine_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.pos_x(pos_x), .pos_y(pos_y), .ext_x(ext_x), .ext_y(ext_y),
		.angle_deg(angle_deg), .res_valid(res_valid), .res_x(res_x), .res_y(res_y),
		.res_w(res_w), .res_h(res_h), .saturated(saturated),
		.fails(fails), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// end the run if nothing transfers for too long
	always @(posedge clk) begin
		if ((start && !busy) || res_valid || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("affine_2d_transform_unit regression: fail");
			$finish;
		end
	end

	// one command transfer; called at a falling edge, returns at one
	task automatic issue(input logic [2:0] op, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] ex, input logic [31:0] ey,
			input logic [31:0] ang);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			gap = $urandom_range(4, 1);
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		opcode = op;
		pos_x = px; pos_y = py; ext_x = ex; ext_y = ey; angle_deg = ang;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	// mostly modest values so transforms stay in range, sometimes wild ones
	function automatic logic [31:0] pick_val();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return 32'($signed($urandom_range(32'h00400000)) - 32'sh00200000);
		endcase
	endfunction

	function automatic logic [31:0] near_one();
		return 32'($signed($urandom_range(32'h00020000)) - 32'sh00008000);
	endfunction

	initial begin
		logic [2:0] op;
		int         sel;
		start = 1'b0;
		opcode = OP_IDENT;
		pos_x = '0; pos_y = '0; ext_x = '0; ext_y = '0; angle_deg = '0;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, every opcode, angle wrap, clamping, spare codes
		issue(OP_POINT, 32'h7fffffff, 32'h80000000, 0, 0, 0);
		issue(OP_RECT, 32'h00010000, 32'h00020000, 32'hfffd0000, 32'hfffc0000, 0);
		issue(OP_RECT, 32'h7fff0000, 32'h7fff0000, 32'h7fffffff, 32'h7fffffff, 0);
		issue(OP_RECT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 0);
		issue(OP_TRANS, 32'h00050000, 32'hfffd0000, 0, 0, 0);
		issue(OP_POINT, 32'h00010000, 32'h00010000, 0, 0, 0);
		issue(OP_ROT, 0, 0, 32'h00010000, 32'h00020000, 32'h005a0000);
		issue(OP_ROT, 0, 0, 0, 0, 32'hff4c0000);
		issue(OP_ROT, 0, 0, 0, 0, 32'h7fffffff);
		issue(OP_ROT, 0, 0, 0, 0, 32'h80000000);
		issue(OP_ROT, 0, 0, 32'h00100000, 0, 32'h01680000);
		issue(OP_ROT, 0, 0, 0, 0, 32'h00b40000);
		issue(OP_RECT, 32'h00010000, 32'h00010000, 32'h00030000, 32'h00020000, 0);
		issue(OP_SCALE, 32'hffff0000, 32'h00020000, 32'h00010000, 32'h00010000, 0);
		issue(OP_SCALE, 0, 0, 32'h7fffffff, 32'h80000000, 0);
		issue(OP_SPARE6, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff);
		issue(OP_SPARE7, 0, 0, 0, 0, 0);
		issue(OP_POINT, 32'h00010000, 32'h00010000, 0, 0, 0);
		issue(OP_IDENT, 0, 0, 0, 0, 0);
		issue(OP_SCALE, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
		issue(OP_TRANS, 32'h7fffffff, 32'h80000000, 0, 0, 0);
		issue(OP_SCALE, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
		issue(OP_POINT, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
		issue(OP_IDENT, 0, 0, 0, 0, 0);

		// random: transform chains restarted from identity, mapping in between
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 31 : (ph == 1) ? 82 : 0;
			for (int n = 0; n < 160; n++) begin
				sel = $urandom_range(99);
				if (sel < 6) op = OP_IDENT;
				else if (sel < 18) op = OP_TRANS;
				else if (sel < 32) op = OP_ROT;
				else if (sel < 44) op = OP_SCALE;
				else if (sel < 70) op = OP_POINT;
				else if (sel < 97) op = OP_RECT;
				else op = 3'($urandom_range(7, 6));
				if (op == OP_SCALE && $urandom_range(3) != 0)
					issue(op, near_one(), near_one(), pick_val(), pick_val(), $urandom);
				else
					issue(op, pick_val(), pick_val(), pick_val(), pick_val(), $urandom);
			end
		end

		// drain and let a trailing spare opcode settle
		start = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fails == 0)
			$display("affine_2d_transform_unit regression: pass");
		else
			$display("affine_2d_transform_unit regression: fail");
		$finish;
	end

endmodule
